@@ hw/rtl/md5_message_digest_macros.svh @@
// ----------------------------------------------------------------------------
// MD5 message digest: assertion macros
// Shared concurrent-assertion wrappers, clocked on clk, quiet while in reset.
// ----------------------------------------------------------------------------
`ifndef MD5_MESSAGE_DIGEST_MACROS_SVH
`define MD5_MESSAGE_DIGEST_MACROS_SVH

// Same-cycle implication.
`define MD5_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MD5_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/md5_pkg.sv @@
// ----------------------------------------------------------------------------
// MD5 package
// Beat types, sequencer states and the MD5 step constants and index tables.
// ----------------------------------------------------------------------------
package md5_pkg;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        last;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic        digest_last;
    } out_beat_t;

    // Four working / chaining words
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } abcd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMPRESS,
        ST_ADD,
        ST_OUT
    } state_t;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [31:0] PAD_BYTE   = 32'h0000_0080;
    localparam logic [3:0]  POS_LEN_LO = 4'd14;
    localparam logic [3:0]  POS_LAST   = 4'd15;
    localparam logic [5:0]  LAST_ROUND = 6'd63;
    localparam logic [2:0]  FULL_COUNT = 3'd4;

    localparam logic [31:0] STEP_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Message word used by step i
    function automatic logic [3:0] msg_index(input logic [5:0] i);
        logic [3:0] idx;
        unique case (i[5:4])
            2'd0: idx = i[3:0];
            2'd1: idx = {i[1:0], 2'b00} + i[3:0] + 4'd1;
            2'd2: idx = {i[2:0], 1'b0} + i[3:0] + 4'd5;
            2'd3: idx = {i[0], 3'b000} - i[3:0];
        endcase
        return idx;
    endfunction

    // Left-rotate amount of step i
    function automatic logic [4:0] rot_amount(input logic [5:0] i);
        logic [4:0] s;
        unique case ({i[5:4], i[1:0]})
            4'h0: s = 5'd7;
            4'h1: s = 5'd12;
            4'h2: s = 5'd17;
            4'h3: s = 5'd22;
            4'h4: s = 5'd5;
            4'h5: s = 5'd9;
            4'h6: s = 5'd14;
            4'h7: s = 5'd20;
            4'h8: s = 5'd4;
            4'h9: s = 5'd11;
            4'ha: s = 5'd16;
            4'hb: s = 5'd23;
            4'hc: s = 5'd6;
            4'hd: s = 5'd10;
            4'he: s = 5'd15;
            4'hf: s = 5'd21;
        endcase
        return s;
    endfunction

endpackage

@@ hw/rtl/md5_round.sv @@
// ----------------------------------------------------------------------------
// MD5 step unit
// One MD5 step: round function, add of the pre-summed constant and message
// word, rotate, add, and the word shuffle.
// ----------------------------------------------------------------------------
module md5_round (
    input  md5_pkg::abcd_t  cur,
    input  logic [5:0]      step,
    input  logic [31:0]     pre,    // K[step] + M[g(step)]
    output md5_pkg::abcd_t  nxt
);

    logic [31:0] f;
    logic [31:0] sum;
    logic [63:0] dbl;
    logic [4:0]  s;

    always_comb
    begin
        unique case (step[5:4])
            2'd0: f = (cur.b & cur.c) | (~cur.b & cur.d);
            2'd1: f = (cur.b & cur.d) | (cur.c & ~cur.d);
            2'd2: f = cur.b ^ cur.c ^ cur.d;
            2'd3: f = cur.c ^ (cur.b | ~cur.d);
        endcase
        s   = md5_pkg::rot_amount(step);
        sum = cur.a + f + pre;
        dbl = {sum, sum} << s;
        nxt.a = cur.d;
        nxt.b = cur.b + dbl[63:32];
        nxt.c = cur.b;
        nxt.d = cur.c;
    end

endmodule

@@ hw/rtl/md5_message_digest.sv @@
// ----------------------------------------------------------------------------
// MD5 message digest
// Hashes one message at a time and returns the 128-bit digest in four beats.
// ----------------------------------------------------------------------------
// Message words arrive one per beat, first byte in bits 7:0. A plain word
// does not stall the input. Every sixteenth word completes a 64-byte block,
// which then runs through the single MD5 step unit one step per cycle, 64
// steps, and is then folded into the chaining value; the input stalls after
// that word until the fold is done. The word marked last is trimmed to
// byte_count bytes (values above four count as four), 0x80 is appended and
// the padding and 64-bit length are written one word per cycle, costing one
// or two more block compressions. The digest then goes out as four beats,
// words A to D, with digest_last on the fourth; the block returns to the
// initial vector as the fourth beat is taken and accepts the next message.
// Input is stalled from the end of the last word until the digest has been
// fully delivered.
// ----------------------------------------------------------------------------
`include "md5_message_digest_macros.svh"

module md5_message_digest (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 word_valid,
    output logic                 word_stall,
    input  md5_pkg::in_beat_t    word_data,
    output logic                 digest_valid,
    input  logic                 digest_stall,
    output md5_pkg::out_beat_t   digest_data
);

    md5_pkg::state_t state_reg, state_next;
    logic [5:0]      round_reg, round_next;
    logic [3:0]      pos_reg, pos_next;
    logic [63:0]     bitlen_reg, bitlen_next;
    md5_pkg::abcd_t  chain_reg, chain_next;
    md5_pkg::abcd_t  work_reg, work_next;
    logic [31:0]     pre_reg, pre_next;
    logic [31:0]     blk_reg [16];
    logic            pend80_reg, pend80_next;   // 0x80 word still to write
    logic            hipend_reg, hipend_next;   // length high word still to write
    logic            final_reg, final_next;     // last block written
    logic            pad_reg, pad_next;         // padding under way
    logic [1:0]      oidx_reg, oidx_next;

    logic            word_acc;
    logic            digest_acc;
    logic [2:0]      cnt;
    logic [31:0]     tail_word;
    logic            push_en;
    logic [31:0]     push_word;
    md5_pkg::abcd_t  step_out;
    logic [5:0]      round_inc;
    logic [31:0]     dig_word;

    md5_round u_round (
        .cur  (work_reg),
        .step (round_reg),
        .pre  (pre_reg),
        .nxt  (step_out)
    );

    // ------------------------------------------------------------------
    // Handshake outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        word_stall   = (state_reg != md5_pkg::ST_IDLE);
        digest_valid = (state_reg == md5_pkg::ST_OUT);
        unique case (oidx_reg)
            2'd0: dig_word = chain_reg.a;
            2'd1: dig_word = chain_reg.b;
            2'd2: dig_word = chain_reg.c;
            2'd3: dig_word = chain_reg.d;
        endcase
        digest_data.digest_word = dig_word;
        digest_data.digest_last = (oidx_reg == 2'd3);
    end

    assign word_acc   = word_valid && !word_stall;
    assign digest_acc = digest_valid && !digest_stall;

    // Final word: trimmed and terminated with 0x80 where it has room
    always_comb
    begin
        cnt = (word_data.byte_count > md5_pkg::FULL_COUNT) ? md5_pkg::FULL_COUNT
                                                           : word_data.byte_count;
        unique case (cnt)
            3'd0:    tail_word = md5_pkg::PAD_BYTE;
            3'd1:    tail_word = {16'h0000, 8'h80, word_data.data_word[7:0]};
            3'd2:    tail_word = {8'h00, 8'h80, word_data.data_word[15:0]};
            3'd3:    tail_word = {8'h80, word_data.data_word[23:0]};
            default: tail_word = word_data.data_word;
        endcase
    end

    // Word written into the block buffer this cycle
    always_comb
    begin
        push_en   = 1'b0;
        push_word = word_data.data_word;
        if (state_reg == md5_pkg::ST_IDLE)
        begin
            push_en   = word_acc;
            push_word = word_data.last ? tail_word : word_data.data_word;
        end
        else if (state_reg == md5_pkg::ST_PAD)
        begin
            push_en = 1'b1;
            priority if (pend80_reg)
                push_word = md5_pkg::PAD_BYTE;
            else if (hipend_reg)
                push_word = bitlen_reg[63:32];
            else if (pos_reg == md5_pkg::POS_LEN_LO)
                push_word = bitlen_reg[31:0];
            else
                push_word = 32'h0000_0000;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            md5_pkg::ST_IDLE:
            begin
                if (word_acc)
                begin
                    if (pos_reg == md5_pkg::POS_LAST)
                        state_next = md5_pkg::ST_COMPRESS;
                    else if (word_data.last)
                        state_next = md5_pkg::ST_PAD;
                end
            end
            md5_pkg::ST_PAD:
            begin
                if (pos_reg == md5_pkg::POS_LAST)
                    state_next = md5_pkg::ST_COMPRESS;
            end
            md5_pkg::ST_COMPRESS:
            begin
                if (round_reg == md5_pkg::LAST_ROUND)
                    state_next = md5_pkg::ST_ADD;
            end
            md5_pkg::ST_ADD:
            begin
                priority if (final_reg)
                    state_next = md5_pkg::ST_OUT;
                else if (pad_reg)
                    state_next = md5_pkg::ST_PAD;
                else
                    state_next = md5_pkg::ST_IDLE;
            end
            md5_pkg::ST_OUT:
            begin
                if (digest_acc && oidx_reg == 2'd3)
                    state_next = md5_pkg::ST_IDLE;
            end
            default: state_next = md5_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: datapath controls
    // ------------------------------------------------------------------
    assign round_inc = round_reg + 6'd1;

    always_comb
    begin
        round_next  = round_reg;
        pos_next    = pos_reg;
        bitlen_next = bitlen_reg;
        chain_next  = chain_reg;
        work_next   = work_reg;
        pre_next    = pre_reg;
        pend80_next = pend80_reg;
        hipend_next = hipend_reg;
        final_next  = final_reg;
        pad_next    = pad_reg;
        oidx_next   = oidx_reg;

        if (push_en)
            pos_next = pos_reg + 4'd1;

        unique case (state_reg)
            md5_pkg::ST_IDLE:
            begin
                if (word_acc)
                begin
                    if (word_data.last)
                    begin
                        bitlen_next = bitlen_reg + {58'd0, cnt, 3'b000};
                        pend80_next = (cnt == md5_pkg::FULL_COUNT);
                        pad_next    = 1'b1;
                    end
                    else
                    begin
                        bitlen_next = bitlen_reg + 64'd32;
                    end
                end
            end
            md5_pkg::ST_PAD:
            begin
                priority if (pend80_reg)
                    pend80_next = 1'b0;
                else if (hipend_reg)
                begin
                    hipend_next = 1'b0;
                    final_next  = 1'b1;
                end
                else if (pos_reg == md5_pkg::POS_LEN_LO)
                    hipend_next = 1'b1;
            end
            md5_pkg::ST_COMPRESS:
            begin
                work_next  = step_out;
                round_next = round_inc;
                pre_next   = md5_pkg::STEP_K[round_inc]
                           + blk_reg[md5_pkg::msg_index(round_inc)];
            end
            md5_pkg::ST_ADD:
            begin
                chain_next.a = chain_reg.a + work_reg.a;
                chain_next.b = chain_reg.b + work_reg.b;
                chain_next.c = chain_reg.c + work_reg.c;
                chain_next.d = chain_reg.d + work_reg.d;
            end
            md5_pkg::ST_OUT:
            begin
                if (digest_acc)
                begin
                    oidx_next = oidx_reg + 2'd1;
                    if (oidx_reg == 2'd3)
                    begin
                        chain_next  = '{a: md5_pkg::IV_A, b: md5_pkg::IV_B,
                                        c: md5_pkg::IV_C, d: md5_pkg::IV_D};
                        bitlen_next = 64'd0;
                        pos_next    = 4'd0;
                        final_next  = 1'b0;
                        pad_next    = 1'b0;
                    end
                end
            end
            default: ;
        endcase

        // Block complete: load working words and pre-sum for step 0.
        // Word 0 is already in the block buffer.
        if (state_next == md5_pkg::ST_COMPRESS && state_reg != md5_pkg::ST_COMPRESS)
        begin
            work_next  = chain_reg;
            round_next = 6'd0;
            pre_next   = md5_pkg::STEP_K[0] + blk_reg[0];
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= md5_pkg::ST_IDLE;
            round_reg  <= 6'd0;
            pos_reg    <= 4'd0;
            bitlen_reg <= 64'd0;
            chain_reg  <= '{a: md5_pkg::IV_A, b: md5_pkg::IV_B,
                            c: md5_pkg::IV_C, d: md5_pkg::IV_D};
            pend80_reg <= 1'b0;
            hipend_reg <= 1'b0;
            final_reg  <= 1'b0;
            pad_reg    <= 1'b0;
            oidx_reg   <= 2'd0;
        end
        else
        begin
            state_reg  <= state_next;
            round_reg  <= round_next;
            pos_reg    <= pos_next;
            bitlen_reg <= bitlen_next;
            chain_reg  <= chain_next;
            pend80_reg <= pend80_next;
            hipend_reg <= hipend_next;
            final_reg  <= final_next;
            pad_reg    <= pad_next;
            oidx_reg   <= oidx_next;
        end
    end

    // Payload: working words, pre-sum and the block buffer
    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        pre_reg  <= pre_next;
        if (push_en)
            blk_reg[pos_reg] <= push_word;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `MD5_ASSERT_NEXT(a_full_block_compresses, clk, rst_n,
        word_acc && !word_data.last && pos_reg == md5_pkg::POS_LAST,
        state_reg == md5_pkg::ST_COMPRESS && round_reg == 6'd0,
        "sixteenth word did not start a compression")
    `MD5_ASSERT_NEXT(a_last_step_folds, clk, rst_n,
        state_reg == md5_pkg::ST_COMPRESS && round_reg == md5_pkg::LAST_ROUND,
        state_reg == md5_pkg::ST_ADD,
        "step 63 not followed by the chaining add")
    `MD5_ASSERT_NOW(a_digest_block_aligned, clk, rst_n,
        digest_valid,
        pos_reg == 4'd0 && final_reg && !pend80_reg && !hipend_reg,
        "digest shown before padding finished")
    `MD5_ASSERT_NEXT(a_restart_clean, clk, rst_n,
        digest_acc && digest_data.digest_last,
        state_reg == md5_pkg::ST_IDLE && bitlen_reg == 64'd0 && !pad_reg
            && chain_reg.a == md5_pkg::IV_A,
        "state not returned to the initial vector after the digest")

endmodule

@@ dv/tb_md5_message_digest.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MD5 message digest testbench
// Message words are driven in random bursts and the digest beats are taken
// behind a receiver that stalls on its own pattern. Each digest beat is checked
// against a local MD5 model or a digest typed into the table. A short directed
// table opens the run: the empty message, "abc", byte counts above four,
// short counts on words that are not last, unused high bytes, and a final
// word that needs a second compression. Random messages of mixed length follow.
// ----------------------------------------------------------------------------
module tb_md5_message_digest;

    // Beats in the random part; no new message is started once this many have gone in
    localparam int RANDOM_WORDS = 170;
    // Padding plus two block compressions, with some margin
    localparam int DRAIN_CYCLES = 200;
    // Long receiver hold-off, so that the block backs up onto its input
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 24;

    localparam logic [31:0] INIT_H [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };
    localparam logic [31:0] PAD_WORD = 32'h0000_0080;
    localparam logic [3:0]  LEN_SLOT = 4'd14;

    localparam logic [31:0] SINE_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Left-rotate amounts, four per round
    localparam int ROT_SH [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    // Well-known digests, words A..D with the first digest byte in bits 7:0
    localparam logic [127:0] DIG_EMPTY =
        {32'hd98c1dd4, 32'h04b2008f, 32'h980980e9, 32'h7e42f8ec};
    localparam logic [127:0] DIG_ABC =
        {32'h98500190, 32'hb04fd23c, 32'h7d3f96d6, 32'h727fe128};

    // Directed table: one message word per row. Where typed is set the
    // digest that the row completes is given here; otherwise the local
    // model supplies it.
    typedef struct packed {
        logic [31:0]  data;
        logic [2:0]   cnt;
        logic         lst;
        logic         typed;
        logic [127:0] dig;
    } dir_row_t;

    localparam int DIR_ROWS = 21;
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        // empty message; every byte of the word is unused and set
        '{32'hffff_ffff, 3'd0, 1'b1, 1'b1, DIG_EMPTY},
        // "abc" with junk in the unused top byte
        '{32'haa63_6261, 3'd3, 1'b1, 1'b1, DIG_ABC},
        // counts above four act as four
        '{32'hffff_ffff, 3'd7, 1'b1, 1'b0, 128'd0},
        '{32'h0000_0000, 3'd5, 1'b1, 1'b0, 128'd0},
        '{32'h8000_0001, 3'd4, 1'b1, 1'b0, 128'd0},
        // fourteen words with byte counts that must be ignored, then a last
        // word in slot 14 that forces a second compression
        '{32'h0000_0000, 3'd0, 1'b0, 1'b0, 128'd0},
        '{32'hffff_ffff, 3'd1, 1'b0, 1'b0, 128'd0},
        '{32'h1234_5678, 3'd2, 1'b0, 1'b0, 128'd0},
        '{32'h8000_0000, 3'd3, 1'b0, 1'b0, 128'd0},
        '{32'h0000_0001, 3'd5, 1'b0, 1'b0, 128'd0},
        '{32'ha5a5_a5a5, 3'd6, 1'b0, 1'b0, 128'd0},
        '{32'h5a5a_5a5a, 3'd7, 1'b0, 1'b0, 128'd0},
        '{32'h0000_0080, 3'd4, 1'b0, 1'b0, 128'd0},
        '{32'hffff_ff7f, 3'd0, 1'b0, 1'b0, 128'd0},
        '{32'h7fff_ffff, 3'd1, 1'b0, 1'b0, 128'd0},
        '{32'hdead_beef, 3'd2, 1'b0, 1'b0, 128'd0},
        '{32'h0f0f_0f0f, 3'd3, 1'b0, 1'b0, 128'd0},
        '{32'hf0f0_f0f0, 3'd6, 1'b0, 1'b0, 128'd0},
        '{32'hcafe_f00d, 3'd7, 1'b0, 1'b0, 128'd0},
        '{32'hdead_beef, 3'd2, 1'b1, 1'b0, 128'd0},
        '{32'hffff_ffff, 3'd6, 1'b1, 1'b0, 128'd0}
    };

    logic                clk   = 1'b0;
    logic                rst_n = 1'b0;
    logic                word_valid   = 1'b0;
    logic                word_stall;
    md5_pkg::in_beat_t   word_data    = '0;
    logic                digest_valid;
    logic                digest_stall = 1'b0;
    md5_pkg::out_beat_t  digest_data;

    always #5 clk = ~clk;

    md5_message_digest u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .word_valid   (word_valid),
        .word_stall   (word_stall),
        .word_data    (word_data),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest_data  (digest_data)
    );

    // ------------------------------------------------------------------------
    // Local MD5 model: chaining value, block buffer, bit count, fill slot
    // ------------------------------------------------------------------------
    logic [31:0] chain_h [4];
    logic [31:0] blk_w [16];
    logic [63:0] msg_bits;
    logic [3:0]  fill_pos;

    md5_pkg::out_beat_t digest_q [$];
    int                 mismatches = 0;

    task automatic md5_compress();
        logic [31:0] a, b, c, d, f, t, sum;
        logic [63:0] rot;
        int g, r;
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        for (int i = 0; i < 64; i++)
        begin
            r = i / 16;
            case (r)
                0:
                begin
                    f = (b & c) | (~b & d);
                    g = i;
                end
                1:
                begin
                    f = (b & d) | (c & ~d);
                    g = (5 * i + 1) % 16;
                end
                2:
                begin
                    f = b ^ c ^ d;
                    g = (3 * i + 5) % 16;
                end
                default:
                begin
                    f = c ^ (b | ~d);
                    g = (7 * i) % 16;
                end
            endcase
            sum = a + f + SINE_K[i] + blk_w[g];
            // rotate left through a doubled copy
            rot = {sum, sum} << ROT_SH[r * 4 + i % 4];
            t = d;
            d = c;
            c = b;
            b = b + rot[63:32];
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
    endtask

    task automatic absorb_word(input logic [31:0] w);
        blk_w[fill_pos] = w;
        fill_pos++;
        if (fill_pos == 4'd0)
            md5_compress();
    endtask

    task automatic md5_restart();
        for (int k = 0; k < 4; k++)
            chain_h[k] = INIT_H[k];
        msg_bits = '0;
        fill_pos = '0;
    endtask

    // One accepted message word; done is set when it closes the message.
    // Bit-count wrap at 2^64 cannot be reached in a run of this length.
    task automatic md5_absorb_beat(input md5_pkg::in_beat_t b, output bit done,
                                   output logic [127:0] dig);
        int unsigned n;
        logic [31:0] mask;
        done = 1'b0;
        dig  = '0;
        if (!b.last)
        begin
            msg_bits += 64'd32;
            absorb_word(b.data_word);
            return;
        end
        n = (b.byte_count > md5_pkg::FULL_COUNT) ? 4 : b.byte_count;
        msg_bits += 64'(n * 8);
        if (n == 4)
        begin
            absorb_word(b.data_word);
            absorb_word(PAD_WORD);
        end
        else
        begin
            mask = (32'h1 << (8 * n)) - 32'h1;
            absorb_word((b.data_word & mask) | (PAD_WORD << (8 * n)));
        end
        while (fill_pos != LEN_SLOT)
            absorb_word('0);
        absorb_word(msg_bits[31:0]);
        absorb_word(msg_bits[63:32]);
        dig  = {chain_h[0], chain_h[1], chain_h[2], chain_h[3]};
        done = 1'b1;
        md5_restart();
    endtask

    // ------------------------------------------------------------------------
    // Sender: bursts of random length, random gaps between them
    // ------------------------------------------------------------------------
    int burst_left = 0;

    task automatic send_word(input md5_pkg::in_beat_t b, input bit typed,
                             input logic [127:0] typed_dig);
        bit done;
        logic [127:0] dig;
        md5_pkg::out_beat_t ob;
        if (burst_left == 0)
        begin
            word_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            // about one burst in four is long, giving stretches with no gaps
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 48)
                                                     : $urandom_range(1, 8);
        end
        word_valid <= 1'b1;
        word_data  <= b;
        do
            @(posedge clk);
        while (word_stall);
        burst_left--;
        md5_absorb_beat(b, done, dig);
        if (done)
        begin
            if (typed)
                dig = typed_dig;
            for (int k = 0; k < 4; k++)
            begin
                ob.digest_word = dig[127 - 32 * k -: 32];
                ob.digest_last = (k == 3);
                digest_q.push_back(ob);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: checks each taken beat, stalls on a rotating pattern, and
    // once holds off for a long stretch to back the block up
    // ------------------------------------------------------------------------
    logic [15:0]        stall_pat  = '0;
    int                 pat_tick   = 0;
    int                 hold_left  = 0;
    bit                 hold_done  = 1'b0;
    int                 beats_seen = 0;
    md5_pkg::out_beat_t want;

    always @(posedge clk)
    begin
        if (rst_n && digest_valid && !digest_stall)
        begin
            beats_seen++;
            if (digest_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: digest beat with none pending: word %h last %b",
                         $time, digest_data.digest_word, digest_data.digest_last);
            end
            else
            begin
                want = digest_q.pop_front();
                if (digest_data.digest_word !== want.digest_word)
                begin
                    mismatches++;
                    $display("%0t: digest_word expected %h actual %h",
                             $time, want.digest_word, digest_data.digest_word);
                end
                if (digest_data.digest_last !== want.digest_last)
                begin
                    mismatches++;
                    $display("%0t: digest_last expected %b actual %b",
                             $time, want.digest_last, digest_data.digest_last);
                end
            end
        end

        pat_tick++;
        if (pat_tick % 64 == 0)
            stall_pat = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom);
        else
            stall_pat = {stall_pat[0], stall_pat[15:1]};

        if (hold_left != 0)
        begin
            hold_left--;
            digest_stall <= 1'b1;
        end
        else if (!hold_done && digest_valid && beats_seen >= HOLD_AFTER)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            digest_stall <= 1'b1;
        end
        else
        begin
            digest_stall <= stall_pat[0];
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        md5_pkg::in_beat_t b;
        int nwords;
        int sent;
        md5_restart();
        for (int k = 0; k < 16; k++)
            blk_w[k] = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            b.data_word  = DIR_TABLE[r].data;
            b.byte_count = DIR_TABLE[r].cnt;
            b.last       = DIR_TABLE[r].lst;
            send_word(b, DIR_TABLE[r].typed, DIR_TABLE[r].dig);
        end

        // random messages; lengths weighted towards short ones, with a share
        // placed near the block boundary so the last word can need two passes
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            case ($urandom_range(0, 9))
                0:       nwords = 0;
                1:       nwords = $urandom_range(13, 15);
                2:       nwords = $urandom_range(29, 31);
                3:       nwords = $urandom_range(32, 40);
                default: nwords = $urandom_range(1, 12);
            endcase
            for (int k = 0; k <= nwords; k++)
            begin
                b.data_word  = $urandom;
                b.byte_count = 3'($urandom_range(0, 7));
                b.last       = (k == nwords);
                send_word(b, 1'b0, '0);
                sent++;
            end
        end
        word_valid <= 1'b0;

        while (digest_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && digest_q.size() == 0)
            $display("[md5_message_digest] OK");
        else
            $display("[md5_message_digest] ERROR");
        $finish;
    end

    // Run limit, far beyond the slowest correct run
    initial
    begin
        #5_000_000;
        $display("[md5_message_digest] ERROR");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/md5_pkg.sv
hw/rtl/md5_round.sv
hw/rtl/md5_message_digest.sv
dv/tb_md5_message_digest.sv
